// ===== rtl/mrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, constants and helpers of the mixed-radix index converter.
// ----------------------------------------------------------------------------
package mrc_pkg;

   localparam int MAX_DIMS       = 4;
   localparam int SIZE_BITS      = 16;
   localparam int COORD_BITS     = 16;
   localparam int INDEX_BITS     = 64;
   localparam int DIMS_BITS      = 3;
   localparam int CSR_IDX_BITS   = 3;
   localparam int STEPS_PER_CELL = 4;
   localparam int CELLS_PER_DIM  = INDEX_BITS / STEPS_PER_CELL;
   localparam int DIV_DIMS       = MAX_DIMS - 1;
   localparam int NUM_DIV_CELLS  = CELLS_PER_DIM * DIV_DIMS;
   localparam int ACC_BITS       = 48;

   // request kinds
   localparam logic REQ_TO_INDEX = 1'b0;
   localparam logic REQ_TO_COORD = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_COORD_RANGE = 2'd1;
   localparam logic [1:0] STATUS_INDEX_RANGE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIMS  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE0 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE1 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE2 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE3 = 3'd4;

   // one item travelling down the chain
   typedef struct packed {
      logic                                valid;
      logic                                rtype;
      logic                                bad;
      logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord;
      logic [INDEX_BITS-1:0]               acc;
      logic [INDEX_BITS-1:0]               x;
      logic [SIZE_BITS-1:0]                rem;
   } stage_type;

   // a zero extent counts as one
   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
      eff_size = (s == '0) ? SIZE_BITS'(1) : s;
   endfunction

endpackage

// ===== rtl/mrc_req_if.sv =====
// ----------------------------------------------------------------------------
// mrc_req_if
// Request channel: coordinate or flat index to convert.
// ----------------------------------------------------------------------------
interface mrc_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] in_coord0;
   logic [15:0] in_coord1;
   logic [15:0] in_coord2;
   logic [15:0] in_coord3;
   logic [63:0] in_flat_index;

   modport source (output valid, req_type, in_coord0, in_coord1, in_coord2, in_coord3,
                   in_flat_index, input ready);
   modport sink (input valid, req_type, in_coord0, in_coord1, in_coord2, in_coord3,
                 in_flat_index, output ready);
endinterface

// ===== rtl/mrc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mrc_rsp_if
// Result channel: flat index, coordinate and status.
// ----------------------------------------------------------------------------
interface mrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_flat_index;
   logic [15:0] out_coord0;
   logic [15:0] out_coord1;
   logic [15:0] out_coord2;
   logic [15:0] out_coord3;
   logic [1:0]  status;

   modport source (output valid, out_flat_index, out_coord0, out_coord1, out_coord2,
                   out_coord3, status, input ready);
   modport sink (input valid, out_flat_index, out_coord0, out_coord1, out_coord2,
                 out_coord3, status, output ready);
endinterface

// ===== rtl/mrc_mac_cell.sv =====
// ----------------------------------------------------------------------------
// mrc_mac_cell
// One Horner step of the coordinate to index path: acc = acc * size + coord.
// ----------------------------------------------------------------------------
module mrc_mac_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           active,
   input  logic [mrc_pkg::SIZE_BITS-1:0]  size,
   input  logic [mrc_pkg::COORD_BITS-1:0] coord,
   input  mrc_pkg::stage_type             stage_in,
   output mrc_pkg::stage_type             stage_out
);
   import mrc_pkg::*;

   stage_type stage_ff;
   stage_type stage_in_w;
   logic [COORD_BITS-1:0] c_used;

   // multiply-accumulate, dimensions past the count add nothing
   always_comb begin
      stage_in_w = stage_in;
      c_used     = active ? coord : '0;
      stage_in_w.acc = INDEX_BITS'(stage_in.acc[ACC_BITS-1:0] * size)
                     + INDEX_BITS'(c_used);
      stage_in_w.bad = stage_in.bad | (active && (coord >= size));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;
endmodule

// ===== rtl/mrc_div_cell.sv =====
// ----------------------------------------------------------------------------
// mrc_div_cell
// Four restoring long-division steps of the index by one dimension size.
// ----------------------------------------------------------------------------
module mrc_div_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [mrc_pkg::SIZE_BITS-1:0] divisor,
   input  mrc_pkg::stage_type            stage_in,
   output mrc_pkg::stage_type            stage_out
);
   import mrc_pkg::*;

   stage_type stage_ff;
   stage_type stage_in_w;
   logic [SIZE_BITS:0]    r;
   logic [INDEX_BITS-1:0] q;

   // shift in one dividend bit per step, subtract where it fits
   always_comb begin
      stage_in_w = stage_in;
      r = {1'b0, stage_in.rem};
      q = stage_in.x;
      for (int k = 0; k < STEPS_PER_CELL; k++) begin
         r = {r[SIZE_BITS-1:0], q[INDEX_BITS-1]};
         q = {q[INDEX_BITS-2:0], 1'b0};
         if (r >= {1'b0, divisor}) begin
            r    = r - {1'b0, divisor};
            q[0] = 1'b1;
         end
      end
      stage_in_w.x   = q;
      stage_in_w.rem = r[SIZE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;
endmodule

// ===== rtl/mixed_radix_index_converter_unit.sv =====
// ----------------------------------------------------------------------------
// mixed_radix_index_converter_unit
// Converts between a coordinate of up to four dimensions and a flat index.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan (valid/ready), results leave on rsp_chan.
// req_type 0 turns a coordinate into a flat index, 1 splits a flat index into
// coordinates. The csr port sets the dimension count and the extents. The
// user must write it only while no transfer is in flight; the block does
// not enforce this. Every request runs down a chain of cells: three
// multiply-accumulate cells (Horner form of the index), then 48 division
// cells of four quotient bits each (16 per divided dimension), then the
// output register, 52 registers in all. One transfer is taken every cycle
// while the receiver does not stall, set by the one-item-per-cell chain.
// When the receiver stalls, the whole chain holds and req_chan.ready drops
// until the output register is taken. Reset empties the chain and sets the
// dimension count to zero and every extent to one.
// ----------------------------------------------------------------------------
module mixed_radix_index_converter_unit (
   input  logic                             clock,
   input  logic                             reset,
   mrc_req_if.sink                          req_chan,
   mrc_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [mrc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [mrc_pkg::SIZE_BITS-1:0]    csr_wdata
);
   import mrc_pkg::*;

   logic [DIMS_BITS-1:0] dims_ff;
   logic [MAX_DIMS-1:0][SIZE_BITS-1:0] size_ff;
   logic [MAX_DIMS-1:0][SIZE_BITS-1:0] eff;
   logic [DIMS_BITS-1:0] n_act;
   logic adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= '0;
         for (int d = 0; d < MAX_DIMS; d++) size_ff[d] <= SIZE_BITS'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DIMS:  dims_ff    <= csr_wdata[DIMS_BITS-1:0];
            CSR_SIZE0: size_ff[0] <= csr_wdata;
            CSR_SIZE1: size_ff[1] <= csr_wdata;
            CSR_SIZE2: size_ff[2] <= csr_wdata;
            CSR_SIZE3: size_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) eff[d] = eff_size(size_ff[d]);
      n_act = (dims_ff > DIMS_BITS'(MAX_DIMS)) ? DIMS_BITS'(MAX_DIMS) : dims_ff;
   end

   // chain moves whenever the output register is free or taken
   logic out_valid_ff;
   assign adv            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // entry: top coordinate seeds the accumulator
   stage_type entry;
   always_comb begin
      entry       = '0;
      entry.valid = req_chan.valid;
      entry.rtype = req_chan.req_type;
      entry.coord[0] = req_chan.in_coord0;
      entry.coord[1] = req_chan.in_coord1;
      entry.coord[2] = req_chan.in_coord2;
      entry.coord[3] = req_chan.in_coord3;
      entry.x     = req_chan.in_flat_index;
      entry.acc   = (n_act > 3'd3) ? INDEX_BITS'(req_chan.in_coord3) : '0;
      entry.bad   = (n_act > 3'd3) && (req_chan.in_coord3 >= eff[3]);
   end

   // multiply-accumulate cells, dimensions two down to zero
   stage_type mac_link [0:DIV_DIMS];
   assign mac_link[0] = entry;
   for (genvar k = 0; k < DIV_DIMS; k++) begin : g_mac
      localparam int D = DIV_DIMS - 1 - k;
      mrc_mac_cell u_mac (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .active    (n_act > DIMS_BITS'(D)),
         .size      (eff[D]),
         .coord     (mac_link[k].coord[D]),
         .stage_in  (mac_link[k]),
         .stage_out (mac_link[k+1])
      );
   end

   // division cells; a group boundary captures the remainder as a coordinate
   stage_type div_out [0:NUM_DIV_CELLS-1];
   for (genvar i = 0; i < NUM_DIV_CELLS; i++) begin : g_div
      localparam int D = i / CELLS_PER_DIM;
      stage_type pre;
      logic [SIZE_BITS-1:0] divisor;
      if (i == 0) begin : g_head
         always_comb begin
            pre       = mac_link[DIV_DIMS];
            pre.coord = '0;
            pre.rem   = '0;
         end
      end else if ((i % CELLS_PER_DIM) == 0) begin : g_bound
         always_comb begin
            pre = div_out[i-1];
            if (DIMS_BITS'(D) < n_act) pre.coord[D-1] = div_out[i-1].rem;
            pre.rem = '0;
         end
      end else begin : g_body
         assign pre = div_out[i-1];
      end
      assign divisor = (DIMS_BITS'(D + 1) < n_act) ? eff[D] : SIZE_BITS'(1);
      mrc_div_cell u_div (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .divisor   (divisor),
         .stage_in  (pre),
         .stage_out (div_out[i])
      );
   end

   // final coordinate capture, top coordinate saturation and status
   stage_type last;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_in;
   logic [INDEX_BITS-1:0] flat_in;
   logic [1:0]            status_in;
   logic [SIZE_BITS-1:0]  s_top;
   logic [1:0]            top;
   always_comb begin
      last     = div_out[NUM_DIV_CELLS-1];
      coord_in = last.coord;
      top      = 2'(n_act - 3'd1);
      s_top    = (n_act != '0) ? eff[top] : SIZE_BITS'(1);
      if (n_act > DIMS_BITS'(DIV_DIMS)) coord_in[DIV_DIMS-1] = last.rem;
      if (n_act != '0) begin
         coord_in[top] = (last.x > INDEX_BITS'({COORD_BITS{1'b1}}))
                       ? {COORD_BITS{1'b1}} : last.x[COORD_BITS-1:0];
      end
      if (last.rtype == REQ_TO_INDEX) begin
         coord_in  = '0;
         flat_in   = last.bad ? '0 : last.acc;
         status_in = last.bad ? STATUS_COORD_RANGE : STATUS_OK;
      end else begin
         flat_in   = '0;
         status_in = (last.x >= INDEX_BITS'(s_top)) ? STATUS_INDEX_RANGE : STATUS_OK;
      end
   end

   // output register
   logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_ff;
   logic [INDEX_BITS-1:0] flat_ff;
   logic [1:0]            status_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         coord_ff  <= coord_in;
         flat_ff   <= flat_in;
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.out_flat_index = flat_ff;
   assign rsp_chan.out_coord0     = coord_ff[0];
   assign rsp_chan.out_coord1     = coord_ff[1];
   assign rsp_chan.out_coord2     = coord_ff[2];
   assign rsp_chan.out_coord3     = coord_ff[3];
   assign rsp_chan.status         = status_ff;
endmodule

// ===== tb/mixed_radix_index_converter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_radix_index_converter_unit_test
// Self-checking bench for the mixed-radix coordinate/index converter.
// ----------------------------------------------------------------------------
// A driver feeds queued requests, a monitor predicts each accepted request
// and compares the result fields in order. The run walks through several
// dimension counts and extents (zero extents and out-of-range counts too),
// each with one of four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module mixed_radix_index_converter_unit_test;
   import mrc_pkg::*;

   localparam int PIPE_WAIT     = 60;
   localparam int STALL_LIMIT   = 4000;
   localparam int NUM_PHASES    = 9;
   localparam int RAND_PER_PHASE = 200;

   typedef struct {
      logic                  rtype;
      logic [15:0]           coord [4];
      logic [INDEX_BITS-1:0] flat;
   } conv_req_type;

   typedef struct {
      logic [INDEX_BITS-1:0] flat;
      logic [15:0]           coord [4];
      logic [1:0]            status;
   } conv_rsp_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [SIZE_BITS-1:0]    csr_wdata;

   mrc_req_if req_chan ();
   mrc_rsp_if rsp_chan ();

   mixed_radix_index_converter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the configuration registers
   logic [2:0]           shadow_dims;
   logic [SIZE_BITS-1:0] shadow_size [4];

   conv_req_type pending_reqs [$];
   conv_rsp_type expected_rsps [$];
   int        mismatch_count;
   int        send_gap_pct;
   int        recv_stall_pct;

   // clock, reset and known input levels
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.req_type = 1'b0;
      req_chan.in_coord0 = '0;
      req_chan.in_coord1 = '0;
      req_chan.in_coord2 = '0;
      req_chan.in_coord3 = '0;
      req_chan.in_flat_index = '0;
      rsp_chan.ready = 1'b0;
      fork
         forever #4 clock = ~clock;
         begin
            repeat (5) @(posedge clock);
            reset <= 1'b0;
         end
      join_none
   end

   function automatic int active_dims();
      return (shadow_dims > 3'd4) ? 4 : int'(shadow_dims);
   endfunction

   function automatic logic [INDEX_BITS-1:0] extent(int d);
      return (shadow_size[d] == '0) ? 64'd1 : {48'd0, shadow_size[d]};
   endfunction

   // product of the extents of all dimensions below d
   function automatic logic [INDEX_BITS-1:0] stride(int d);
      logic [INDEX_BITS-1:0] p;
      p = 64'd1;
      for (int k = 0; k < d; k++) p = p * extent(k);
      return p;
   endfunction

   function automatic logic [INDEX_BITS-1:0] element_count();
      return stride(active_dims());
   endfunction

   // expected result of one conversion under the current configuration
   function automatic conv_rsp_type convert(conv_req_type r);
      conv_rsp_type          o;
      int                    n;
      logic                  bad;
      logic [INDEX_BITS-1:0] acc;
      logic [INDEX_BITS-1:0] x;
      logic [INDEX_BITS-1:0] q;
      n = active_dims();
      o.flat = '0;
      o.status = STATUS_OK;
      for (int d = 0; d < 4; d++) o.coord[d] = '0;
      if (r.rtype == REQ_TO_INDEX) begin
         bad = 1'b0;
         acc = '0;
         for (int d = 0; d < n; d++) begin
            if ({48'd0, r.coord[d]} >= extent(d)) bad = 1'b1;
            acc = acc + stride(d) * r.coord[d];
         end
         if (bad) o.status = STATUS_COORD_RANGE;
         else o.flat = acc;
      end else begin
         x = r.flat;
         if (x >= element_count()) o.status = STATUS_INDEX_RANGE;
         if (n > 0) begin
            // top coordinate saturates, the lower ones come from div/mod
            q = x / stride(n - 1);
            o.coord[n-1] = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
            x = x % stride(n - 1);
            for (int d = n - 1; d > 0; d--) begin
               q = x / stride(d - 1);
               o.coord[d-1] = q[15:0];
               x = x % stride(d - 1);
            end
         end
      end
      return o;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic conv_req_type random_request();
      conv_req_type          r;
      int                    n;
      int                    pick;
      logic [INDEX_BITS-1:0] cnt;
      n = active_dims();
      cnt = element_count();
      r.rtype = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      for (int d = 0; d < 4; d++) begin
         if (pick < 75 && d < n) r.coord[d] = 16'($urandom_range(0, int'(extent(d)) - 1));
         else r.coord[d] = 16'($urandom);
      end
      // occasionally one component sits exactly on its extent
      if (pick >= 75 && pick < 85 && n > 0) begin
         int k;
         k = $urandom_range(0, n - 1);
         r.coord[k] = 16'(extent(k));
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) r.flat = rand64() % cnt;
      else if (pick < 75) r.flat = cnt - 64'd1 + $urandom_range(0, 3);
      else r.flat = rand64();
      return r;
   endfunction

   function automatic conv_req_type make_request(logic t, logic [15:0] c0, logic [15:0] c1,
                                                 logic [15:0] c2, logic [15:0] c3,
                                                 logic [63:0] f);
      conv_req_type r;
      r.rtype = t;
      r.coord[0] = c0; r.coord[1] = c1; r.coord[2] = c2; r.coord[3] = c3;
      r.flat = f;
      return r;
   endfunction

   // append one request to the driver queue
   task automatic queue_request(conv_req_type r);
      pending_reqs = {pending_reqs, r};
   endtask

   // corner requests for the current configuration
   task automatic queue_corner_requests();
      logic [15:0] top [4];
      for (int d = 0; d < 4; d++) top[d] = 16'(extent(d) - 64'd1);
      queue_request(make_request(REQ_TO_INDEX, top[0], top[1], top[2], top[3], '0));
      queue_request(make_request(REQ_TO_INDEX, '0, '0, '0, '0, '1));
      queue_request(make_request(REQ_TO_INDEX, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, '0));
      queue_request(make_request(REQ_TO_COORD, '0, '0, '0, '0, '0));
      queue_request(make_request(REQ_TO_COORD, '1, '1, '1, '1,
                                 element_count() - 1));
      queue_request(make_request(REQ_TO_COORD, '0, '0, '0, '0, element_count()));
      queue_request(make_request(REQ_TO_COORD, '0, '0, '0, '0, '1));
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_DIMS) shadow_dims = val[2:0];
      else shadow_size[idx - CSR_SIZE0] = val;
   endtask

   task automatic configure(logic [2:0] dims, logic [15:0] s0, logic [15:0] s1,
                            logic [15:0] s2, logic [15:0] s3);
      csr_write(CSR_DIMS, {13'd0, dims});
      csr_write(CSR_SIZE0, s0);
      csr_write(CSR_SIZE1, s1);
      csr_write(CSR_SIZE2, s2);
      csr_write(CSR_SIZE3, s3);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_chan.valid)
         @(posedge clock);
      repeat (PIPE_WAIT) @(posedge clock);
   endtask

   // stimulus sequence: one configuration and idling pattern per phase
   initial begin
      mismatch_count = 0;
      send_gap_pct = 0;
      recv_stall_pct = 0;
      shadow_dims = '0;
      for (int d = 0; d < 4; d++) shadow_size[d] = 16'd1;
      wait (reset == 1'b0);
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            1: configure(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: configure(3'd3, 16'd7, 16'd5, 16'd0, 16'd9);
            3: configure(3'd1, 16'hFFFF, 16'd1, 16'd1, 16'd1);
            4: configure(3'd7, 16'd3, 16'd4, 16'd5, 16'd6);
            5: configure(3'd2, 16'd1, 16'd1, 16'd200, 16'd300);
            6: configure(3'd4, 16'd2, 16'd3, 16'd1, 16'hFFFF);
            7: configure(3'd5, 16'd0, 16'd0, 16'd0, 16'd0);
            8: configure(3'd4, 16'd16, 16'd256, 16'd100, 16'd37);
            default: ;
         endcase
         case (ph % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
            default: begin send_gap_pct = 17; recv_stall_pct = 17; end
         endcase
         if (ph < 3) queue_corner_requests();
         for (int i = 0; i < RAND_PER_PHASE; i++) queue_request(random_request());
         wait_drained();
      end
      if (mismatch_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      logic         load;
      conv_req_type r;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         load = pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct;
         if (load) begin
            r = pending_reqs.pop_front();
            req_chan.req_type <= r.rtype;
            req_chan.in_coord0 <= r.coord[0];
            req_chan.in_coord1 <= r.coord[1];
            req_chan.in_coord2 <= r.coord[2];
            req_chan.in_coord3 <= r.coord[3];
            req_chan.in_flat_index <= r.flat;
         end
         req_chan.valid <= load;
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= $urandom_range(0, 99) >= recv_stall_pct;
   end

   // predict on request transfer, compare on result transfer
   always @(posedge clock) begin
      conv_req_type r;
      conv_rsp_type e;
      if (!reset && req_chan.valid && req_chan.ready) begin
         r = make_request(req_chan.req_type, req_chan.in_coord0, req_chan.in_coord1,
                          req_chan.in_coord2, req_chan.in_coord3, req_chan.in_flat_index);
         expected_rsps = {expected_rsps, convert(r)};
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsps.size() == 0) begin
            $error("result transfer with nothing expected");
            mismatch_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_chan.out_flat_index !== e.flat) begin
               $error("out_flat_index: expected %0h, got %0h", e.flat, rsp_chan.out_flat_index);
               mismatch_count++;
            end
            if (rsp_chan.out_coord0 !== e.coord[0]) begin
               $error("out_coord0: expected %0d, got %0d", e.coord[0], rsp_chan.out_coord0);
               mismatch_count++;
            end
            if (rsp_chan.out_coord1 !== e.coord[1]) begin
               $error("out_coord1: expected %0d, got %0d", e.coord[1], rsp_chan.out_coord1);
               mismatch_count++;
            end
            if (rsp_chan.out_coord2 !== e.coord[2]) begin
               $error("out_coord2: expected %0d, got %0d", e.coord[2], rsp_chan.out_coord2);
               mismatch_count++;
            end
            if (rsp_chan.out_coord3 !== e.coord[3]) begin
               $error("out_coord3: expected %0d, got %0d", e.coord[3], rsp_chan.out_coord3);
               mismatch_count++;
            end
            if (rsp_chan.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_chan.status);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: cycles with work outstanding but no transfer on either side
   always @(posedge clock) begin
      int stuck_cycles;
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_chan.valid)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule
